@@ rtl/bpm_pkg.sv @@
package bpm_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned LenW       = 5;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 64;

  typedef enum logic [1:0] {
    OpByte   = 2'd0,
    OpTick   = 2'd1,
    OpArm    = 2'd2,
    OpCancel = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StIdle     = 2'd0,
    StBusy     = 2'd1,
    StMatched  = 2'd2,
    StTimedOut = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegPatLo   = 2'd0,
    RegPatHi   = 2'd1,
    RegLen     = 2'd2,
    RegTimeout = 2'd3
  } reg_e;

  typedef struct packed {
    logic [63:0]     pat_lo;
    logic [63:0]     pat_hi;
    logic [LenW-1:0] len;
    logic [31:0]     timeout;
  } cfg_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] progress;
  } res_t;

  function automatic logic [7:0] pattern_byte(cfg_t cfg, logic [3:0] idx);
    logic [127:0] all;
    all = {cfg.pat_hi, cfg.pat_lo};
    return all[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [LenW-1:0] used_length(logic [LenW-1:0] len);
    logic [LenW-1:0] n;
    n = len;
    if (n == '0) n = LenW'(1);
    if (n > LenW'(MaxPattern)) n = LenW'(MaxPattern);
    return n;
  endfunction

endpackage

@@ rtl/bpm_cfg.sv @@
module bpm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [bpm_pkg::ApbDataW-1:0]   pwdata,
  output logic [bpm_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output bpm_pkg::cfg_t                  cfg_o
);
  import bpm_pkg::*;

  cfg_t  cfg_q;
  reg_e  sel;
  logic  wr_en;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_lo  <= '0;
      cfg_q.pat_hi  <= '0;
      cfg_q.len     <= LenW'(1);
      cfg_q.timeout <= '1;
    end else if (wr_en) begin
      case (sel)
        RegPatLo:   cfg_q.pat_lo  <= pwdata;
        RegPatHi:   cfg_q.pat_hi  <= pwdata;
        RegLen:     cfg_q.len     <= pwdata[LenW-1:0];
        RegTimeout: cfg_q.timeout <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      RegPatLo:   prdata = cfg_q.pat_lo;
      RegPatHi:   prdata = cfg_q.pat_hi;
      RegLen:     prdata = ApbDataW'(cfg_q.len);
      RegTimeout: prdata = ApbDataW'(cfg_q.timeout);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/bpm_core.sv @@
module bpm_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  bpm_pkg::op_e   op_i,
  input  logic [7:0]     byte_i,
  input  bpm_pkg::cfg_t  cfg_i,
  output bpm_pkg::res_t  res_o
);
  import bpm_pkg::*;

  logic            armed_q, armed_d;
  logic [LenW-1:0] prog_q, prog_d, prog_inc;
  logic [31:0]     el_q, el_d, el_inc;
  logic [LenW-1:0] len_used;
  status_e         status;

  assign len_used = used_length(cfg_i.len);

  always_comb begin
    armed_d  = armed_q;
    prog_d   = prog_q;
    el_d     = el_q;
    status   = StIdle;
    prog_inc = '0;
    el_inc   = '0;
    case (op_i)
      OpArm: begin
        armed_d = 1'b1;
        prog_d  = '0;
        el_d    = '0;
        status  = StBusy;
      end
      OpCancel: begin
        armed_d = 1'b0;
      end
      OpByte: begin
        if (armed_q) begin
          if (byte_i == pattern_byte(cfg_i, prog_q[3:0])) begin
            prog_inc = prog_q + LenW'(1);
          end else if (byte_i == pattern_byte(cfg_i, 4'd0)) begin
            prog_inc = LenW'(1);
          end else begin
            prog_inc = '0;
          end
          prog_d = prog_inc;
          if (prog_inc >= len_used) begin
            armed_d = 1'b0;
            status  = StMatched;
          end else begin
            status  = StBusy;
          end
        end
      end
      OpTick: begin
        if (armed_q) begin
          el_inc = (&el_q) ? el_q : el_q + 32'd1;
          el_d   = el_inc;
          if (el_inc > cfg_i.timeout) begin
            armed_d = 1'b0;
            status  = StTimedOut;
          end else begin
            status  = StBusy;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.status   = status;
  assign res_o.progress = prog_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      prog_q  <= '0;
      el_q    <= '0;
    end else if (adv_i) begin
      armed_q <= armed_d;
      prog_q  <= prog_d;
      el_q    <= el_d;
    end
  end

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q <= LenW'(MaxPattern))
    else $error("progress beyond pattern size");

  a_arm_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && op_i == OpArm |=> armed_q && prog_q == '0 && el_q == '0)
    else $error("arm did not restart matcher");

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (status == StMatched || status == StTimedOut) |=> !armed_q)
    else $error("still armed after match or timeout");

  a_el_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && op_i == OpArm) |=> el_q >= $past(el_q))
    else $error("elapsed count went backwards");

endmodule

@@ rtl/byte_pattern_matcher_timeout.sv @@
// An accepted input word waits in the input register; when it advances, the
// matcher state updates and the result goes to the result register. One word
// per cycle is taken while the output is ready; an untaken result stalls input.
// rst_ni is asynchronous active low: it clears the matcher (disarmed,
// progress and elapsed zero), both pipeline stages, and loads register defaults.
module byte_pattern_matcher_timeout (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]                    s_axis_tuser,  // [1:0] operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [4:0] match_progress
  output logic [1:0]                    m_axis_tuser,  // [1:0] status
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bpm_pkg::ApbDataW-1:0]  pwdata,
  output logic [bpm_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bpm_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_valid_q;
  op_e        op_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  bpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .op_i   (op_q),
    .byte_i (byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= op_e'(s_axis_tuser);
      byte_q <= s_axis_tdata;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{(8 - LenW){1'b0}}, out_q.progress};

endmodule
